// File: rtl/core/crc8_fpb_pkg.sv
// ----------------------------------------------------------------------------
// crc8_fpb_pkg
// Shared types, constants and the CRC-8 byte update for the framed packet
// builder.
// ----------------------------------------------------------------------------
package crc8_fpb_pkg;

  // CRC-8, polynomial 0x31, no reflection, no final XOR
  localparam logic [7:0] CRC_POLY  = 8'h31;
  localparam logic [7:0] CRC_INIT  = 8'hFF;
  localparam logic [7:0] CRC_TOP   = 8'h80;

  localparam logic [7:0] START_RESET = 8'hAA;

  // number of CRC stages: type byte plus four value bytes
  localparam int unsigned NUM_STAGES = 5;

  // byte positions inside one frame, in transmission order
  localparam logic [2:0] POS_START = 3'd0;
  localparam logic [2:0] POS_TYPE  = 3'd1;
  localparam logic [2:0] POS_VAL0  = 3'd2;
  localparam logic [2:0] POS_VAL1  = 3'd3;
  localparam logic [2:0] POS_VAL2  = 3'd4;
  localparam logic [2:0] POS_VAL3  = 3'd5;
  localparam logic [2:0] POS_CRC   = 3'd6;

  // one packet as it moves through the CRC stages
  typedef struct packed {
    logic [7:0]  packet_type;
    logic [31:0] value_bits;
    logic [7:0]  crc;
  } fpb_item_t;

  // one CRC byte update, MSB first, eight shift steps
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/crc8_fpb_crc_pipe.sv
// ----------------------------------------------------------------------------
// crc8_fpb_crc_pipe
// Five-stage CRC pipeline: stage 0 folds in the type byte, stages 1..4 fold
// in the value bytes, least significant first. Per-stage valid and stall.
// ----------------------------------------------------------------------------
module crc8_fpb_crc_pipe (
  input  logic                    clk,
  input  logic                    rst,
  // incoming beat
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [7:0]              packet_type,
  input  logic [31:0]             value_bits,
  // finished item toward the serializer
  output logic                    done_valid,
  input  logic                    done_ready,
  output crc8_fpb_pkg::fpb_item_t done_item
);
  import crc8_fpb_pkg::*;

  fpb_item_t                 stage [NUM_STAGES];
  logic [NUM_STAGES-1:0]     vld;
  logic [NUM_STAGES-1:0]     rdy;

  // a stage can take a new item when it is empty or its item moves on
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || done_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign item_stall = !rdy[0];
  assign done_valid = vld[NUM_STAGES-1];
  assign done_item  = stage[NUM_STAGES-1];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= item_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage payload: each stage folds one byte into the running CRC
  always_ff @(posedge clk) begin
    if (rdy[0] && item_valid) begin
      stage[0].packet_type <= packet_type;
      stage[0].value_bits  <= value_bits;
      stage[0].crc         <= crc8_byte(CRC_INIT, packet_type);
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k] && vld[k-1]) begin
        stage[k].packet_type <= stage[k-1].packet_type;
        stage[k].value_bits  <= stage[k-1].value_bits;
        stage[k].crc         <= crc8_byte(stage[k-1].crc,
                                          stage[k-1].value_bits[8*(k-1) +: 8]);
      end
    end
  end

  // last stage holds its item while the serializer is busy
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (vld[NUM_STAGES-1] && !done_ready) |=>
      (vld[NUM_STAGES-1] && $stable(stage[NUM_STAGES-1])))
    else $error("crc pipe lost or changed a held item");

  // back pressure only when the first stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> vld[0])
    else $error("crc pipe stalled while empty");

  // an item in the next-to-last stage moves on when there is room
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (vld[NUM_STAGES-2] && rdy[NUM_STAGES-1]) |=> vld[NUM_STAGES-1])
    else $error("crc pipe dropped an item");

endmodule

// File: rtl/core/crc8_framed_packet_builder_top.sv
// ----------------------------------------------------------------------------
// crc8_framed_packet_builder_top
// Builds a 7-byte frame per packet: start byte, type byte, four value bytes
// (LSB first) and a CRC-8 (poly 0x31, init 0xFF) over the five payload bytes.
// ----------------------------------------------------------------------------
// Each accepted packet leaves as seven beats on the frame channel, one beat
// per cycle when the frame side does not stall; last_byte marks the CRC beat.
// The frame channel sets the sustained packet rate.
// The CRC is built in a five-stage pipeline, one payload byte per stage;
// packets keep entering the pipeline while an earlier frame is being
// sent, and frames follow each other with no idle cycle. The start byte
// comes from the configuration register, which is always ready.
module crc8_framed_packet_builder_top (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // packet input
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  packet_type,
  input  logic [31:0] value_bits,
  // frame output
  output logic        frame_valid,
  input  logic        frame_stall,
  output logic [7:0]  frame_byte,
  output logic        last_byte
);
  import crc8_fpb_pkg::*;

  logic       start_byte;
  logic [7:0] start_reg;

  logic       pipe_valid;
  logic       pipe_ready;
  fpb_item_t  pipe_item;

  logic       ser_valid;
  logic [2:0] ser_pos;
  logic [2:0] ser_pos_next;
  fpb_item_t  ser_item;
  logic       beat_done;
  logic       load;

  // start byte register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg <= START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_reg <= cfg_data;
    end
  end

  // CRC pipeline
  crc8_fpb_crc_pipe u_pipe (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .packet_type (packet_type),
    .value_bits  (value_bits),
    .done_valid  (pipe_valid),
    .done_ready  (pipe_ready),
    .done_item   (pipe_item)
  );

  // serializer handshake
  assign beat_done    = ser_valid && !frame_stall;
  assign start_byte   = (ser_pos == POS_START);
  assign pipe_ready   = !ser_valid || (beat_done && ser_pos == POS_CRC);
  assign load         = pipe_valid && pipe_ready;
  assign ser_pos_next = ser_pos + 3'd1;

  // serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_pos   <= POS_START;
    end else if (load) begin
      ser_valid <= 1'b1;
      ser_pos   <= POS_START;
    end else if (beat_done) begin
      if (ser_pos == POS_CRC) begin
        ser_valid <= 1'b0;
        ser_pos   <= POS_START;
      end else begin
        ser_pos <= ser_pos_next;
      end
    end
  end

  // serializer payload
  always_ff @(posedge clk) begin
    if (load) begin
      ser_item <= pipe_item;
    end
  end

  // beat select
  always_comb begin
    case (ser_pos)
      POS_START: frame_byte = start_reg;
      POS_TYPE:  frame_byte = ser_item.packet_type;
      POS_VAL0:  frame_byte = ser_item.value_bits[7:0];
      POS_VAL1:  frame_byte = ser_item.value_bits[15:8];
      POS_VAL2:  frame_byte = ser_item.value_bits[23:16];
      POS_VAL3:  frame_byte = ser_item.value_bits[31:24];
      POS_CRC:   frame_byte = ser_item.crc;
      default:   frame_byte = start_reg;
    endcase
  end

  assign frame_valid = ser_valid;
  assign last_byte   = (ser_pos == POS_CRC);

  // a frame only opens on the start byte position after a load
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (frame_valid && start_byte))
    else $error("frame did not open on the start byte");

  // a non-final beat is followed by the next position of the same frame
  a_step: assert property (@(posedge clk) disable iff (rst)
    (beat_done && !last_byte) |=>
      (frame_valid && ser_pos == $past(ser_pos_next)))
    else $error("frame beat skipped or repeated");

  // position counter never runs past the CRC byte
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ser_pos <= POS_CRC)
    else $error("frame position out of range");

  // with nothing waiting, the channel goes quiet after the CRC beat
  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    (beat_done && last_byte && !pipe_valid) |=> !frame_valid)
    else $error("beat shown with no frame pending");

endmodule

// File: bench/crc8_framed_packet_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_framed_packet_builder testbench
// Sends packets through the builder under several stall patterns and start
// byte settings. Every accepted frame beat is checked against a local frame
// predictor that computes the start byte, payload bytes and CRC-8.
// ----------------------------------------------------------------------------
module testbench;
  import crc8_fpb_pkg::*;

  localparam int FRAME_BEATS   = 7;
  localparam int DRAIN_CYCLES  = 12;
  localparam int HOLD_CYCLES   = 60;
  localparam int RANDOM_PER_PH = 45;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [31:0] value;
  } packet_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  packet_type = 8'h00;
  logic [31:0] value_bits = 32'h0;
  logic        frame_valid;
  logic        frame_stall = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_byte;

  packet_beat_t pending_q[$];
  frame_beat_t  frame_expect_q[$];
  logic [7:0]   start_mirror = START_RESET;
  bit           item_taken = 1'b0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_req_cnt = 0;
  int           error_count = 0;

  crc8_framed_packet_builder_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .packet_type (packet_type),
    .value_bits  (value_bits),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

  always #6 clk = ~clk;

  // CRC-8 over one byte, feedback taken bit by bit, MSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[7] ^ b[k];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  // expected frame for one packet, appended to the expectation store
  task automatic predict_frame(input logic [7:0] sof, input packet_beat_t pkt);
    logic [7:0] payload [5];
    logic [7:0] crc;
    payload[0] = pkt.ptype;
    for (int i = 0; i < 4; i++) payload[i + 1] = pkt.value[8 * i +: 8];
    crc = CRC_INIT;
    frame_expect_q.push_back('{data: sof, last: 1'b0});
    for (int i = 0; i < 5; i++) begin
      crc = crc8_fold(crc, payload[i]);
      frame_expect_q.push_back('{data: payload[i], last: 1'b0});
    end
    frame_expect_q.push_back('{data: crc, last: 1'b1});
  endtask

  // packet driver: new beat at the falling edge once the last one was taken
  always @(negedge clk) begin : drive_packets
    packet_beat_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        item_valid  <= 1'b1;
        packet_type <= nxt.ptype;
        value_bits  <= nxt.value;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // frame receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin : drive_stall
    int hold_left;
    int hold_seen;
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      frame_stall <= 1'b1;
    end else begin
      frame_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: config mirror, packet prediction and frame beat check
  always @(posedge clk) begin : monitor
    frame_beat_t exp_beat;
    item_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) start_mirror = cfg_data;
      if (item_valid && !item_stall) begin
        item_taken = 1'b1;
        predict_frame(start_mirror, '{ptype: packet_type, value: value_bits});
      end
      if (frame_valid && !frame_stall) begin
        if (frame_expect_q.size() == 0) begin
          $display("%0t: unexpected frame beat, actual byte %02h last %0b",
                   $time, frame_byte, last_byte);
          error_count++;
        end else begin
          exp_beat = frame_expect_q.pop_front();
          if (frame_byte !== exp_beat.data) begin
            $display("%0t: frame_byte mismatch, expected %02h actual %02h",
                     $time, exp_beat.data, frame_byte);
            error_count++;
          end
          if (last_byte !== exp_beat.last) begin
            $display("%0t: last_byte mismatch, expected %0b actual %0b",
                     $time, exp_beat.last, last_byte);
            error_count++;
          end
        end
      end
    end
  end

  task automatic queue_packet(input logic [7:0] t, input logic [31:0] v);
    pending_q.push_back('{ptype: t, value: v});
  endtask

  // random packets: mostly known types, values biased toward edge words
  task automatic queue_random_packets(input int n);
    logic [7:0]  t;
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      t = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
      case ($urandom_range(7))
        0:       v = 32'h0000_0000;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'h7FC0_0000 ^ 32'($urandom_range(255));
        default: v = $urandom;
      endcase
      queue_packet(t, v);
    end
  endtask

  // wait until all packets are sent and every frame beat has arrived
  task automatic wait_drained();
    while (pending_q.size() != 0 || item_valid || frame_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset start byte, type and value extremes, float specials
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_packet(8'h00, 32'h0000_0000);
    queue_packet(8'hFF, 32'hFFFF_FFFF);
    queue_packet(8'h01, 32'h0000_0001);
    queue_packet(8'h02, 32'h8000_0000);
    queue_packet(8'h03, 32'h7F80_0000);
    queue_packet(8'h80, 32'h7FC0_0000);
    queue_packet(8'h7F, 32'hFF80_0000);
    queue_packet(8'h04, 32'h3F80_0000);
    queue_packet(8'hAA, 32'h5555_5555);
    queue_packet(8'h55, 32'hAAAA_AAAA);
    queue_packet(8'h00, 32'h1234_5678);
    queue_packet(8'hFE, 32'h0000_00FF);
    wait_drained();

    // long receiver hold-off while packets keep coming, no idling
    hold_req_cnt++;
    queue_random_packets(RANDOM_PER_PH);
    wait_drained();

    // sender idle most of the time, zero start byte
    write_start_byte(8'h00);
    send_idle_pct = 70;
    queue_random_packets(RANDOM_PER_PH);
    wait_drained();

    // receiver stalling most of the time, all-ones start byte
    write_start_byte(8'hFF);
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    queue_random_packets(RANDOM_PER_PH);
    wait_drained();

    // both sides idling, random start byte
    write_start_byte(8'($urandom_range(255)));
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    queue_random_packets(RANDOM_PER_PH);
    wait_drained();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_800_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/core/crc8_fpb_pkg.sv
rtl/core/crc8_fpb_crc_pipe.sv
rtl/core/crc8_framed_packet_builder_top.sv
bench/crc8_framed_packet_builder_tb.sv
